// File: rtl/dvli_pkg.sv
// shared constants and types for the delayed value linear interpolator
`default_nettype none
package dvli_pkg;
    localparam int TIME_ENTRIES = 256;
    localparam int VALUE_ROWS   = 4096;
    localparam int STAGES       = 4;
    localparam int TIME_AW      = $clog2(TIME_ENTRIES);
    localparam int STAGE_W      = 2;
    localparam int VAL_AW       = $clog2(VALUE_ROWS * STAGES);
    localparam int ROW_W        = 12;
    localparam int CNT_W        = 9;

    localparam logic [1:0] CMD_TIME  = 2'd0;
    localparam logic [1:0] CMD_VALUE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] REG_STRIDE_EN = 2'd0;
    localparam logic [1:0] REG_STRIDE    = 2'd1;

    typedef struct packed {
        logic        start;
        logic [63:0] mag;
        logic [63:0] dt;
        logic [63:0] span;
    } dvli_mdreq_t;
endpackage
`default_nettype wire

// File: rtl/dvli_ram.sv
// generic single port ram with registered read
`default_nettype none
module dvli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/dvli_muldiv.sv
// multi-cycle 64x64 multiply then 128/64 restoring divide
`default_nettype none
module dvli_muldiv (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dvli_pkg::dvli_mdreq_t req,
    output logic                       done,
    output logic [63:0]                quot
);
    localparam logic [2:0] MS_IDLE = 3'd0;
    localparam logic [2:0] MS_MUL  = 3'd1;
    localparam logic [2:0] MS_DIV  = 3'd2;
    localparam logic [2:0] MS_DONE = 3'd3;

    logic [2:0]   state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [63:0]  a_reg, b_reg, d_reg, rem_reg, lo_reg, q_reg;
    logic [127:0] acc_reg;
    logic [63:0]  a_next, b_next, d_next, rem_next, lo_next, q_next;
    logic [127:0] acc_next;
    logic [63:0]  pp;
    logic [64:0]  sh;

    assign done = (state_reg == MS_DONE);
    assign quot = q_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        lo_next = lo_reg;
        q_next = q_reg;
        acc_next = acc_reg;
        pp = 64'(a_reg[31:0] * b_reg[31:0]);
        sh = {rem_reg, lo_reg[63]};
        case (state_reg)
            MS_IDLE:
            begin
                if (req.start)
                begin
                    a_next = req.mag;
                    b_next = req.dt;
                    d_next = req.span;
                    acc_next = '0;
                    cnt_next = '0;
                    state_next = MS_MUL;
                end
            end
            MS_MUL:
            begin
                // one 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo, hi*hi
                acc_next = acc_reg + ({64'd0, pp} << {cnt_reg[0], 5'd0} << {cnt_reg[1], 5'd0});
                if (cnt_reg[1:0] != 2'd3)
                begin
                    b_next = {b_reg[31:0], b_reg[63:32]};
                end
                if (cnt_reg[1:0] == 2'd1)
                begin
                    a_next = {a_reg[31:0], a_reg[63:32]};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    rem_next = acc_next[127:64];
                    lo_next = acc_next[63:0];
                    q_next = '0;
                    cnt_next = '0;
                    state_next = MS_DIV;
                end
            end
            MS_DIV:
            begin
                lo_next = {lo_reg[62:0], 1'b0};
                if (sh >= {1'b0, d_reg})
                begin
                    rem_next = 64'(sh - {1'b0, d_reg});
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = sh[63:0];
                    q_next = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = MS_DONE;
                end
            end
            MS_DONE:
            begin
                state_next = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        d_reg <= d_next;
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        q_reg <= q_next;
        acc_reg <= acc_next;
    end
endmodule
`default_nettype wire

// File: rtl/delayed_value_linear_interpolator.sv
// top level of the delayed value linear interpolator
//
// channel | dir | handshake        | beat
// s_axis  | in  | tvalid/tready    | cmd,row_index,stage,data_word,current_time,delay_amount,valid_count
// m_axis  | out | tvalid/tready    | interp_value in tdata, found and is_query in tuser
// apb     | in  | psel/penable     | stride_enable at 0x0, row_stride at 0x4
//
// a write goes straight to the output; a query scans the time intervals in turn, then
// reads the two value rows, runs the multiply and then the divide
// the scan reads one time entry at a time from the single port time memory
// reset clears control only; memories are undefined until written
// one beat at a time; a held result stalls the next beat
`default_nettype none
module delayed_value_linear_interpolator (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: cmd, row_index, stage, data_word, current_time, delay_amount, valid_count, pad
    input  wire logic [223:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: interp_value
    output logic [63:0]       m_axis_tdata,
    // tuser: found, is_query
    output logic [1:0]        m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_V0    = 4'd4;
    localparam logic [3:0] S_V1    = 4'd5;
    localparam logic [3:0] S_V1W   = 4'd6;
    localparam logic [3:0] S_MD    = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic        se_reg;
    logic [4:0]  stride_reg;
    logic [1:0]  cmd;
    logic [11:0] row_in;
    logic [1:0]  stage_in;
    logic [63:0] data_in, cur_in, dly_in;
    logic [8:0]  cnt_in;

    logic [1:0]  stage_reg;
    logic [63:0] target_reg, t0_reg, v0_reg, res_reg;
    logic [8:0]  idx_reg, count_reg;
    logic        found_reg, isq_reg;
    logic [8:0]  idx_next;
    logic [63:0] diff;
    logic        ovf;
    logic [63:0] target_next;

    logic                        t_we;
    logic [dvli_pkg::TIME_AW-1:0] t_addr;
    logic [63:0]                 t_rdata;
    logic                        v_we;
    logic [dvli_pkg::VAL_AW-1:0] v_addr;
    logic [63:0]                 v_rdata;
    logic [17:0]                 r0, r1;
    dvli_pkg::dvli_mdreq_t       mreq;
    logic                        md_done;
    logic [63:0]                 md_q;
    logic                        up;
    logic                        acc;

    assign cmd      = s_axis_tdata[1:0];
    assign row_in   = s_axis_tdata[13:2];
    assign stage_in = s_axis_tdata[15:14];
    assign data_in  = s_axis_tdata[79:16];
    assign cur_in   = s_axis_tdata[143:80];
    assign dly_in   = s_axis_tdata[207:144];
    assign cnt_in   = s_axis_tdata[216:208];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = res_reg;
    assign m_axis_tuser = {isq_reg, found_reg};
    assign pready = 1'b1;
    assign prdata = (paddr[2] == dvli_pkg::REG_STRIDE[0]) ? {27'd0, stride_reg} : {31'd0, se_reg};

    assign diff = cur_in - dly_in;
    assign ovf = (cur_in[63] != dly_in[63]) && (cur_in[63] != diff[63]);
    assign target_next = ovf ? (cur_in[63] ? 64'h8000000000000000 : 64'h7fffffffffffffff) : diff;

    assign r1 = se_reg ? 18'(idx_reg * stride_reg) : 18'(idx_reg);
    assign r0 = se_reg ? 18'(18'(idx_reg - 9'd1) * stride_reg) : 18'(idx_reg - 9'd1);
    assign up = ($signed(v0_reg) <= $signed(v_rdata));

    always_comb
    begin
        t_we = 1'b0;
        t_addr = idx_reg[dvli_pkg::TIME_AW-1:0];
        v_we = 1'b0;
        v_addr = {r0[11:0], stage_reg};
        if (state_reg == S_IDLE)
        begin
            t_addr = row_in[dvli_pkg::TIME_AW-1:0];
            v_addr = {row_in, stage_in};
            t_we = acc && cmd == dvli_pkg::CMD_TIME && row_in < 12'(dvli_pkg::TIME_ENTRIES);
            v_we = acc && cmd == dvli_pkg::CMD_VALUE;
        end
        else if (state_reg == S_V1)
        begin
            v_addr = {r1[11:0], stage_reg};
        end
        if (state_reg == S_RD0 || state_reg == S_CMP)
        begin
            t_addr = idx_reg[dvli_pkg::TIME_AW-1:0];
        end
    end

    dvli_ram #(.WIDTH(64), .DEPTH(dvli_pkg::TIME_ENTRIES)) u_time (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(data_in), .rdata(t_rdata));
    dvli_ram #(.WIDTH(64), .DEPTH(dvli_pkg::VALUE_ROWS * dvli_pkg::STAGES)) u_value (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(data_in), .rdata(v_rdata));

    always_comb
    begin
        mreq.start = (state_reg == S_V1W);
        mreq.mag = up ? (v_rdata - v0_reg) : (v0_reg - v_rdata);
        mreq.dt = target_reg - t0_reg;
        mreq.span = 64'(t_rdata - t0_reg);
    end

    dvli_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(mreq), .done(md_done), .quot(md_q));

    // t_rdata keeps t1 after the compare since the time memory rereads the same entry
    logic up_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (cmd == dvli_pkg::CMD_QUERY)
                    begin
                        state_next = (cnt_in < 9'd2) ? S_OUT : S_RD0;
                        idx_next = 9'd0;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RD0:
            begin
                idx_next = idx_reg + 9'd1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_RD1;
                if ($signed(t0_reg) <= $signed(target_reg) && $signed(target_reg) < $signed(t_rdata))
                begin
                    if (r1 < 18'(dvli_pkg::VALUE_ROWS) && r0 < 18'(dvli_pkg::VALUE_ROWS))
                        state_next = S_V0;
                    else
                        state_next = S_OUT;
                end
                else if (idx_reg + 9'd1 >= count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 9'd1;
                end
            end
            S_V0:   state_next = S_V1;
            S_V1:   state_next = S_V1W;
            S_V1W:  state_next = S_MD;
            S_MD:   state_next = S_WAIT;
            S_WAIT: if (md_done) state_next = S_OUT;
            S_OUT:  if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            se_reg <= 1'b0;
            stride_reg <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == dvli_pkg::REG_STRIDE[0])
                    stride_reg <= pwdata[4:0];
                else
                    se_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (state_reg == S_IDLE && acc)
        begin
            stage_reg <= stage_in;
            target_reg <= target_next;
            count_reg <= (cnt_in > 9'(dvli_pkg::TIME_ENTRIES)) ? 9'(dvli_pkg::TIME_ENTRIES) : cnt_in;
            isq_reg <= (cmd == dvli_pkg::CMD_QUERY);
            found_reg <= 1'b0;
            res_reg <= '0;
        end
        if (state_reg == S_RD1)
        begin
            t0_reg <= t_rdata;
        end
        if (state_reg == S_CMP && state_next == S_RD1)
        begin
            t0_reg <= t_rdata;
        end
        if (state_reg == S_V1)
        begin
            v0_reg <= v_rdata;
        end
        if (state_reg == S_V1W)
        begin
            up_reg <= up;
        end
        if (state_reg == S_WAIT && md_done)
        begin
            res_reg <= up_reg ? (v0_reg + md_q) : (v0_reg - md_q);
            found_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: rtl/dvli_checker.sv
// port level checks for the interpolator, bound to the top level
`default_nettype none
module dvli_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    // no new beat while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // not found means zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("nonzero result without found");
    // found only on queries
    a_fq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1]) else $error("found on write");
endmodule

bind delayed_value_linear_interpolator dvli_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));
`default_nettype wire

// File: verif/delayed_value_linear_interpolator_tb.sv
// self-checking testbench for the delayed value linear interpolator
`default_nettype none
module delayed_value_linear_interpolator_tb;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  TAIL_CYCLES = 700;
    localparam logic [1:0] CMD_NOP = 2'd3;

    typedef struct {
        logic [1:0]         cmd;
        logic [11:0]        row;
        logic [1:0]         stage;
        logic signed [63:0] data;
        logic signed [63:0] now;
        logic signed [63:0] delay;
        logic [8:0]         count;
    } req_t;

    typedef struct {
        logic [63:0] value;
        logic        found;
        logic        is_query;
    } answer_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    delayed_value_linear_interpolator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state, updated as beats are accepted
    logic [63:0] tbl_time [dvli_pkg::TIME_ENTRIES];
    logic [63:0] tbl_val  [dvli_pkg::VALUE_ROWS][dvli_pkg::STAGES];
    // stimulus shadow, updated as beats are queued
    logic [63:0] plan_time [dvli_pkg::TIME_ENTRIES];
    bit          plan_time_ok [dvli_pkg::TIME_ENTRIES];
    bit          plan_val_ok  [dvli_pkg::VALUE_ROWS][dvli_pkg::STAGES];

    logic        stride_on;
    logic [4:0]  row_stride;
    bit          quiet;

    req_t        pending_reqs[$];
    answer_t     expected_answers[$];
    req_t        cur_req;
    int          queued_cnt;
    int          checked_cnt;
    int          query_cnt;
    int          hit_cnt;
    int          err_cnt;
    int          src_gap;
    int          sink_wait;
    int          hold_cnt;
    bit          hold_done;
    int          cycle_cnt;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] target_of(logic [63:0] now, logic [63:0] delay);
        logic signed [64:0] d;
        d = $signed({now[63], now}) - $signed({delay[63], delay});
        if (d > $signed({1'b0, 64'h7fff_ffff_ffff_ffff}))
            return 64'h7fff_ffff_ffff_ffff;
        if (d < $signed({1'b1, 64'h8000_0000_0000_0000}))
            return 64'h8000_0000_0000_0000;
        return d[63:0];
    endfunction

    function automatic logic [63:0] time_at(bit from_plan, int k);
        return from_plan ? plan_time[k] : tbl_time[k];
    endfunction

    // index of the first interval holding tgt, 0 when none
    function automatic int find_span(bit from_plan, logic [63:0] tgt, logic [8:0] count);
        int n;
        logic [63:0] t0;
        logic [63:0] t1;
        n = (count > dvli_pkg::TIME_ENTRIES) ? dvli_pkg::TIME_ENTRIES : int'(count);
        for (int i = 1; i < n; i++)
        begin
            t0 = time_at(from_plan, i - 1);
            t1 = time_at(from_plan, i);
            if ($signed(t0) <= $signed(tgt) && $signed(tgt) < $signed(t1))
                return i;
        end
        return 0;
    endfunction

    function automatic int row_of(int i);
        return stride_on ? i * int'(row_stride) : i;
    endfunction

    function automatic answer_t interpolate(req_t r);
        answer_t     a;
        logic [63:0] tgt;
        logic [63:0] t0;
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] mag;
        logic [127:0] q;
        int          i;
        int          r0;
        int          r1;
        a = '{value: '0, found: 1'b0, is_query: 1'b0};
        case (r.cmd)
            dvli_pkg::CMD_TIME:
                if (r.row < dvli_pkg::TIME_ENTRIES)
                    tbl_time[r.row] = r.data;
            dvli_pkg::CMD_VALUE:
                tbl_val[r.row][r.stage] = r.data;
            dvli_pkg::CMD_QUERY:
            begin
                a.is_query = 1'b1;
                tgt = target_of(r.now, r.delay);
                i = find_span(1'b0, tgt, r.count);
                r0 = row_of(i - 1);
                r1 = row_of(i);
                if (i > 0 && r0 < dvli_pkg::VALUE_ROWS && r1 < dvli_pkg::VALUE_ROWS)
                begin
                    t0 = tbl_time[i - 1];
                    v0 = tbl_val[r0][r.stage];
                    v1 = tbl_val[r1][r.stage];
                    mag = ($signed(v0) <= $signed(v1)) ? v1 - v0 : v0 - v1;
                    q = ({64'b0, mag} * {64'b0, tgt - t0}) / {64'b0, tbl_time[i] - t0};
                    a.value = ($signed(v0) <= $signed(v1)) ? v0 + q[63:0] : v0 - q[63:0];
                    a.found = 1'b1;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic queue_req(req_t r);
        if (r.cmd == dvli_pkg::CMD_TIME && r.row < dvli_pkg::TIME_ENTRIES)
        begin
            plan_time[r.row] = r.data;
            plan_time_ok[r.row] = 1'b1;
        end
        if (r.cmd == dvli_pkg::CMD_VALUE)
            plan_val_ok[r.row][r.stage] = 1'b1;
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic queue_write(logic [1:0] cmd, int row, int stage, logic [63:0] data);
        req_t r;
        r = '{cmd: cmd, row: 12'(row), stage: 2'(stage), data: data,
              now: rnd64(), delay: rnd64(), count: 9'($urandom)};
        queue_req(r);
    endtask

    // only the written prefix of the time table is ever scanned, and value
    // entries that the query will read are written first
    task automatic queue_query(logic [63:0] now, logic [63:0] delay, int count, int stage);
        req_t r;
        int   filled;
        int   i;
        int   rows[2];
        filled = 0;
        while (filled < dvli_pkg::TIME_ENTRIES && plan_time_ok[filled])
            filled++;
        if (filled == 0)
            return;
        if (count > filled && filled < dvli_pkg::TIME_ENTRIES)
            count = filled;
        i = find_span(1'b1, target_of(now, delay), 9'(count));
        rows[0] = row_of(i - 1);
        rows[1] = row_of(i);
        if (i > 0 && rows[0] < dvli_pkg::VALUE_ROWS && rows[1] < dvli_pkg::VALUE_ROWS)
            foreach (rows[k])
                if (!plan_val_ok[rows[k]][stage])
                    queue_write(dvli_pkg::CMD_VALUE, rows[k], stage, rnd64());
        r = '{cmd: dvli_pkg::CMD_QUERY, row: 12'($urandom), stage: 2'(stage), data: rnd64(),
              now: now, delay: delay, count: 9'(count)};
        queue_req(r);
    endtask

    // query aimed inside interval k, or anywhere when the interval is empty
    task automatic queue_hit(int k, int count, int stage);
        logic [63:0] span;
        logic [63:0] tgt;
        logic [63:0] delay;
        span = plan_time[k] - plan_time[k - 1];
        if ($signed(plan_time[k]) > $signed(plan_time[k - 1]))
            tgt = plan_time[k - 1] + rnd64() % span;
        else
            tgt = rnd64();
        delay = ($urandom_range(0, 3) == 0) ? rnd64() >> $urandom_range(1, 63) : 64'(0);
        queue_query(tgt + delay, delay, count, stage);
    endtask

    task automatic wait_drained();
        while (checked_cnt != queued_cnt)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == dvli_pkg::REG_STRIDE_EN)
            stride_on = d[0];
        else
            row_stride = d[4:0];
    endtask

    // queues about n beats, counting the value writes that queries pull in
    task automatic random_phase(int n);
        int          pick;
        int          k;
        int          cnt;
        int          base;
        logic [63:0] mid;
        base = queued_cnt;
        while (queued_cnt - base < n)
        begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(1, dvli_pkg::TIME_ENTRIES - 1);
            cnt = $urandom_range(0, 7) == 0 ? $urandom_range(0, 511) : $urandom_range(k + 1, 256);
            if (pick < 50)
                queue_hit(k, cnt, $urandom_range(0, 3));
            else if (pick < 60)
                queue_query(rnd64(), rnd64(), $urandom_range(0, 511), $urandom_range(0, 3));
            else if (pick < 78)
                queue_write(dvli_pkg::CMD_VALUE, $urandom_range(0, 4095), $urandom_range(0, 3),
                            rnd64());
            else if (pick < 88)
            begin
                if (k < dvli_pkg::TIME_ENTRIES - 1)
                begin
                    mid = plan_time[k - 1] + ((plan_time[k + 1] - plan_time[k - 1]) >> 1);
                    queue_write(dvli_pkg::CMD_TIME, k, 0, mid);
                end
            end
            else if (pick < 92)
                queue_write(dvli_pkg::CMD_TIME, $urandom_range(0, 4095), $urandom_range(0, 3),
                            rnd64());
            else if (pick < 96)
                queue_write(dvli_pkg::CMD_TIME, $urandom_range(dvli_pkg::TIME_ENTRIES, 4095), 0,
                            rnd64());
            else
                queue_write(CMD_NOP, $urandom_range(0, 4095), $urandom_range(0, 3), rnd64());
        end
    endtask

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // beat source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_answers.push_back(interpolate(cur_req));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {7'b0, cur_req.count, cur_req.delay, cur_req.now,
                                     cur_req.data, cur_req.stage, cur_req.row, cur_req.cmd};
                    s_axis_tvalid <= 1'b1;
                    src_gap <= quiet ? 0 : $urandom_range(0, 19);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall, started once after 350 checked beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && checked_cnt >= 350)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= 800;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result sink and checker
    always @(posedge clk or negedge rst_n)
    begin : sink
        answer_t exp_a;
        int      n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end
        else
        begin
            n = sink_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected beat, actual value %h found %b query %b",
                             $time, m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                end
                else
                begin
                    exp_a = expected_answers.pop_front();
                    if (exp_a.is_query)
                    begin
                        query_cnt++;
                        hit_cnt += exp_a.found;
                    end
                    if (m_axis_tdata !== exp_a.value || m_axis_tuser[0] !== exp_a.found
                            || m_axis_tuser[1] !== exp_a.is_query)
                    begin
                        err_cnt++;
                        $display("%0t: mismatch exp %h found %b query %b, got %h found %b query %b",
                                 $time, exp_a.value, exp_a.found, exp_a.is_query,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                    end
                    checked_cnt++;
                end
                n = quiet ? 0 : $urandom_range(0, 19);
            end
            else if (n > 0)
            begin
                n--;
            end
            sink_wait <= n;
            m_axis_tready <= (n == 0) && (hold_cnt == 0) && !(!hold_done && checked_cnt >= 350);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] t;
        int          settings[6][2];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stride_on = 1'b0;
        row_stride = 5'd1;
        quiet = 1'b0;
        queued_cnt = 0;
        checked_cnt = 0;
        query_cnt = 0;
        hit_cnt = 0;
        err_cnt = 0;
        cycle_cnt = 0;
        settings = '{'{1, 1}, '{1, 16}, '{1, 0}, '{1, 31}, '{0, 7}, '{1, 3}};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: table edges, ignored writes, saturation, short counts
        cfg_write(dvli_pkg::REG_STRIDE_EN, 32'd0);
        cfg_write(dvli_pkg::REG_STRIDE, 32'd1);
        queue_write(dvli_pkg::CMD_TIME, 0, 0, 64'h8000_0000_0000_0000);
        queue_write(dvli_pkg::CMD_TIME, 1, 0, 64'h0000_0001_0000_0000);
        queue_write(dvli_pkg::CMD_TIME, 2, 3, 64'h0000_0002_0000_0000);
        queue_write(dvli_pkg::CMD_TIME, 3, 0, 64'h7fff_ffff_ffff_ffff);
        queue_write(dvli_pkg::CMD_TIME, 4095, 3, 64'h7fff_ffff_ffff_ffff);
        queue_write(dvli_pkg::CMD_VALUE, 4095, 3, 64'hffff_ffff_ffff_ffff);
        queue_write(dvli_pkg::CMD_VALUE, 0, 2, 64'h7fff_ffff_ffff_ffff);
        queue_write(dvli_pkg::CMD_VALUE, 1, 2, 64'h8000_0000_0000_0000);
        queue_write(CMD_NOP, 4095, 3, 64'hffff_ffff_ffff_ffff);
        queue_query(64'h0000_0001_8000_0000, 64'h0, 4, 0);
        queue_query(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0001, 4, 2);
        queue_query(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 4, 1);
        queue_query(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 4, 3);
        queue_query(64'h0000_0002_0000_0000, 64'h0000_0000_0000_0001, 4, 3);
        queue_query(64'h0000_0001_8000_0000, 64'h0, 0, 0);
        queue_query(64'h0000_0001_8000_0000, 64'h0, 1, 0);
        queue_query(64'h0000_0001_8000_0000, 64'h0, 2, 2);
        wait_drained();

        // fill the whole time table in rising order
        t = 64'hffff_ff00_0000_0000 + ($urandom & 32'hffff);
        for (int i = 0; i < dvli_pkg::TIME_ENTRIES; i++)
        begin
            queue_write(dvli_pkg::CMD_TIME, i, $urandom_range(0, 3), t);
            t = t + 1 + ({$urandom, $urandom} >> $urandom_range(28, 62));
        end
        random_phase(220);
        wait_drained();

        foreach (settings[p])
        begin
            cfg_write(dvli_pkg::REG_STRIDE_EN, 32'(settings[p][0]));
            cfg_write(dvli_pkg::REG_STRIDE, 32'(settings[p][1]) | ($urandom & 32'hffff_ffe0));
            quiet = (p % 3 == 2);
            random_phase(220);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d beats, %0d queries of which %0d found an interval",
                 checked_cnt, query_cnt, hit_cnt);
        $display("stride settings went through off, 0, 1, 3, 7, 16 and 31");
        if (err_cnt == 0 && expected_answers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
